// File: src/assert_macros.svh
// assertion macros included by the lookup top module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define TDL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tdl assertion failed");

// next-cycle implication
`define TDL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tdl assertion failed");

`endif

// File: src/tdl_pkg.sv
// types, constants and helper functions of the tag dictionary lookup
package tdl_pkg;

  localparam int unsigned EXACT_DEPTH_DEF   = 8192;
  localparam int unsigned PATTERN_DEPTH_DEF = 128;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_EXACT_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_COUNT = 1'b1;

  localparam logic [1:0] KIND_LOAD_EXACT   = 2'd0;
  localparam logic [1:0] KIND_LOAD_PATTERN = 2'd1;
  localparam logic [1:0] KIND_LOOKUP       = 2'd2;

  localparam logic [2:0] CLS_EXACT        = 3'd0;
  localparam logic [2:0] CLS_WILDCARD     = 3'd1;
  localparam logic [2:0] CLS_GROUP_LENGTH = 3'd2;
  localparam logic [2:0] CLS_PRIV_CREATOR = 3'd3;
  localparam logic [2:0] CLS_PRIVATE      = 3'd4;
  localparam logic [2:0] CLS_UNKNOWN      = 3'd5;

  localparam logic [15:0] CREATOR_ELEM_LO = 16'h0010;
  localparam logic [15:0] CREATOR_ELEM_HI = 16'h00ff;

  typedef struct packed {
    logic [1:0]  kind;
    logic [12:0] slot;
    logic [31:0] tag_value;
    logic [7:0]  nibble_mask;
    logic [12:0] entry_index;
  } tdl_in_t;

  typedef struct packed {
    logic        found;
    logic [12:0] registry_index;
    logic [2:0]  tag_class;
    logic        group_length;
  } tdl_out_t;

  typedef struct packed {
    logic [31:0] tag;
    logic [7:0]  mask;
    logic [12:0] index;
  } pat_entry_t;

  typedef enum logic [1:0] {
    ORD_LT,
    ORD_EQ,
    ORD_GT
  } ord_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_E_REQ,
    ST_E_CMP,
    ST_E_FIN,
    ST_P_INIT,
    ST_P_REQ,
    ST_P_CMP,
    ST_P_FIN
  } state_e;

  // order of a pattern against a key; the highest unmasked differing nibble decides
  function automatic ord_e pattern_order(pat_entry_t pat, logic [31:0] key);
    ord_e       res;
    logic [3:0] a;
    logic [3:0] b;
    res = ORD_EQ;
    for (int i = 0; i < 8; i++) begin
      a = pat.tag[4*i +: 4];
      b = key[4*i +: 4];
      if (!pat.mask[i] && (a != b)) begin
        res = (a < b) ? ORD_LT : ORD_GT;
      end
    end
    return res;
  endfunction

  // class of a tag that matched nothing
  function automatic logic [2:0] miss_class(logic [31:0] key);
    logic [2:0] cls;
    if (key[15:0] == 16'h0000) begin
      cls = CLS_GROUP_LENGTH;
    end else if (key[16]) begin
      cls = ((key[15:0] >= CREATOR_ELEM_LO) && (key[15:0] <= CREATOR_ELEM_HI)) ?
            CLS_PRIV_CREATOR : CLS_PRIVATE;
    end else begin
      cls = CLS_UNKNOWN;
    end
    return cls;
  endfunction

endpackage

// File: src/tag_dictionary_lookup_top.sv
// tag dictionary lookup: binary search over sorted exact and wildcard tables
// the exact table is searched first and, on a miss, the wildcard table; the result and strobe are
//   registered, so the strobe comes in the next cycle after the search ends
// one lookup at a time, the next word taken with the strobe
// loads and configuration writes complete in the cycle they are taken; results cannot stall
// reset clears counts, control and strobe; table contents are undefined until loaded
`include "assert_macros.svh"

module tag_dictionary_lookup_top #(
  parameter int unsigned EXACT_DEPTH   = tdl_pkg::EXACT_DEPTH_DEF,
  parameter int unsigned PATTERN_DEPTH = tdl_pkg::PATTERN_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  tdl_pkg::tdl_in_t                in_i,
  output logic                            result_valid_o,
  output tdl_pkg::tdl_out_t               result_o,
  input  logic                            cfg_we_i,
  input  logic [tdl_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tdl_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import tdl_pkg::*;

  localparam int unsigned EW = $clog2(EXACT_DEPTH);
  localparam int unsigned PW = $clog2(PATTERN_DEPTH);
  localparam int unsigned IW = (EW > PW) ? EW : PW;

  // configuration registers
  logic [13:0] exact_count_q;
  logic [7:0]  pattern_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exact_count_q   <= '0;
      pattern_count_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_EXACT_COUNT:   exact_count_q   <= cfg_data_i;
        CFG_PATTERN_COUNT: pattern_count_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // search bounds: last valid position of each table, counts clamped to the depth
  logic        ex_empty, pt_empty;
  logic [IW-1:0] ex_last, pt_last;

  always_comb begin
    ex_empty = (exact_count_q == '0);
    pt_empty = (pattern_count_q == '0);
    if (32'(exact_count_q) >= 32'(EXACT_DEPTH)) begin
      ex_last = IW'(32'(EXACT_DEPTH) - 32'd1);
    end else begin
      ex_last = IW'(32'(exact_count_q) - 32'd1);
    end
    if (32'(pattern_count_q) >= 32'(PATTERN_DEPTH)) begin
      pt_last = IW'(32'(PATTERN_DEPTH) - 32'd1);
    end else begin
      pt_last = IW'(32'(pattern_count_q) - 32'd1);
    end
  end

  // an item is taken when start is high while idle; loads write the tables right away
  state_e state_q, state_d;
  logic   take;
  logic   ex_we, pt_we;

  assign busy_o = (state_q != ST_IDLE);
  assign take   = start_i && !busy_o;
  assign ex_we  = take && (in_i.kind == KIND_LOAD_EXACT) &&
                  (32'(in_i.slot) < 32'(EXACT_DEPTH));
  assign pt_we  = take && (in_i.kind == KIND_LOAD_PATTERN) &&
                  (32'(in_i.slot) < 32'(PATTERN_DEPTH));

  // table memories, one write and one registered read port each
  logic [31:0] ex_mem [EXACT_DEPTH];
  pat_entry_t  pt_mem [PATTERN_DEPTH];
  logic [31:0] ex_rdata_q;
  pat_entry_t  pt_rdata_q;
  pat_entry_t  pt_wdata;
  logic        ex_re, pt_re;
  logic [IW-1:0] rd_idx;

  assign pt_wdata = '{tag: in_i.tag_value, mask: in_i.nibble_mask, index: in_i.entry_index};

  always_ff @(posedge clk_i) begin
    if (ex_we) begin
      ex_mem[EW'(32'(in_i.slot))] <= in_i.tag_value;
    end
    if (ex_re) begin
      ex_rdata_q <= ex_mem[rd_idx[EW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pt_we) begin
      pt_mem[PW'(32'(in_i.slot))] <= pt_wdata;
    end
    if (pt_re) begin
      pt_rdata_q <= pt_mem[rd_idx[PW-1:0]];
    end
  end

  // search control: lo/hi are shared by both searches, key held for the whole lookup
  logic [IW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [IW:0]   mid_sum;
  logic [IW-1:0] mid;
  logic [31:0]   key_q;
  logic [31:0]   lo_wide;
  logic          done;
  tdl_out_t      res_d, result_q;
  logic          result_valid_q;
  ord_e          pt_ord;

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[IW:1];
  assign lo_wide = 32'(lo_q);
  assign pt_ord  = pattern_order(pt_rdata_q, key_q);

  always_comb begin
    state_d = state_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    ex_re   = 1'b0;
    pt_re   = 1'b0;
    rd_idx  = lo_q;
    done    = 1'b0;
    res_d   = '{found: 1'b0, registry_index: '0, tag_class: miss_class(key_q),
                group_length: (key_q[15:0] == 16'h0000)};
    unique case (state_q)
      ST_IDLE: begin
        lo_d = '0;
        hi_d = ex_last;
        if (take && (in_i.kind == KIND_LOOKUP)) begin
          state_d = ex_empty ? ST_P_INIT : ST_E_REQ;
        end
      end
      ST_E_REQ: begin
        // probe the middle while the range is open, else fetch the final candidate
        ex_re = 1'b1;
        if (lo_q < hi_q) begin
          rd_idx  = mid;
          state_d = ST_E_CMP;
        end else begin
          state_d = ST_E_FIN;
        end
      end
      ST_E_CMP: begin
        if (ex_rdata_q < key_q) begin
          lo_d = mid + IW'(1);
        end else begin
          hi_d = mid;
        end
        state_d = ST_E_REQ;
      end
      ST_E_FIN: begin
        if (ex_rdata_q == key_q) begin
          done                 = 1'b1;
          res_d.found          = 1'b1;
          res_d.registry_index = lo_wide[12:0];
          res_d.tag_class      = CLS_EXACT;
          state_d              = ST_IDLE;
        end else begin
          state_d = ST_P_INIT;
        end
      end
      ST_P_INIT: begin
        lo_d = '0;
        hi_d = pt_last;
        if (pt_empty) begin
          done    = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_P_REQ;
        end
      end
      ST_P_REQ: begin
        pt_re = 1'b1;
        if (lo_q < hi_q) begin
          rd_idx  = mid;
          state_d = ST_P_CMP;
        end else begin
          state_d = ST_P_FIN;
        end
      end
      ST_P_CMP: begin
        if (pt_ord == ORD_LT) begin
          lo_d = mid + IW'(1);
        end else begin
          hi_d = mid;
        end
        state_d = ST_P_REQ;
      end
      ST_P_FIN: begin
        done    = 1'b1;
        state_d = ST_IDLE;
        if (pt_ord == ORD_EQ) begin
          res_d.found          = 1'b1;
          res_d.registry_index = pt_rdata_q.index;
          res_d.tag_class      = CLS_WILDCARD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      lo_q           <= '0;
      hi_q           <= '0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      lo_q           <= lo_d;
      hi_q           <= hi_d;
      result_valid_q <= done;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (take) begin
      key_q <= in_i.tag_value;
    end
    if (done) begin
      result_q <= res_d;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  // checks
  `TDL_ASSERT_IMP(a_word_when_idle, result_valid_o, !busy_o)
  `TDL_ASSERT_NXT(a_single_strobe, result_valid_o, !result_valid_o)
  `TDL_ASSERT_IMP(a_miss_index_zero, result_valid_o && !result_o.found,
                  result_o.registry_index == '0)
  `TDL_ASSERT_IMP(a_range_ordered, (state_q == ST_E_REQ) || (state_q == ST_P_REQ),
                  lo_q <= hi_q)
  `TDL_ASSERT_NXT(a_lookup_goes_busy, take && (in_i.kind == KIND_LOOKUP), busy_o)

endmodule
